// ===== design/mbrx_pkg.sv =====
`timescale 1ns / 1ps

package mbrx_pkg;

  // Frame length in bytes, address byte and both CRC bytes included.
  localparam logic [3:0] FRAME_LEN = 4'd7;

  // Byte positions within a frame (position 0 means idle).
  localparam logic [3:0] POS_IDLE     = 4'd0;
  localparam logic [3:0] POS_CRC_LAST = FRAME_LEN - 4'd3;
  localparam logic [3:0] POS_CRC_HIGH = FRAME_LEN - 4'd2;
  localparam logic [3:0] POS_LAST     = FRAME_LEN - 4'd1;
  localparam logic [3:0] POS_DATA_END = 4'd4;

  // CRC-16/MODBUS constants, reflected form.
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef logic [3:0] pos_t;

  // One finished frame summary.
  typedef struct packed {
    logic [15:0] crc_error_total;
    logic [7:0]  data_byte_c;
    logic [7:0]  data_byte_b;
    logic [7:0]  data_byte_a;
    logic        crc_good;
    logic [7:0]  function_code;
  } result_t;

  // Byte-wise CRC update: eight shift and conditional-xor steps.
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== design/mbrx_frame.sv =====
`timescale 1ns / 1ps

module mbrx_frame import mbrx_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] slave_address,
  input  logic       byte_valid,
  input  logic       byte_take,
  input  logic [7:0] rx_byte,
  output logic       result_hit,
  output result_t    result
);

  pos_t        byte_position;
  pos_t        byte_position_next;
  logic [15:0] running_crc;
  logic [15:0] running_crc_next;
  logic [7:0]  frame_bytes [4];
  logic [7:0]  crc_high_received;
  logic [15:0] error_tally;
  logic [15:0] error_tally_next;
  logic [15:0] crc_seed;
  logic [15:0] crc_stepped;
  logic        crc_match;

  // CRC update restarts from the initial value on the address byte.
  assign crc_seed    = (byte_position == POS_IDLE) ? CRC_INIT : running_crc;
  assign crc_stepped = crc_update(crc_seed, rx_byte);
  assign crc_match   = (running_crc == {crc_high_received, rx_byte});

  // The word in hand closes a frame when it lands on the last position.
  assign result_hit = byte_valid && (byte_position == POS_LAST);

  // Position, CRC and error count for the word in hand.
  always_comb begin
    byte_position_next = byte_position;
    running_crc_next   = running_crc;
    error_tally_next   = error_tally;
    if (byte_position == POS_IDLE) begin
      if (rx_byte == slave_address) begin
        byte_position_next = 4'd1;
        running_crc_next   = crc_stepped;
      end
    end else if (byte_position == POS_LAST) begin
      byte_position_next = POS_IDLE;
      running_crc_next   = CRC_INIT;
      if (!crc_match) begin
        error_tally_next = error_tally + 16'd1;
      end
    end else begin
      byte_position_next = byte_position + 4'd1;
      if (byte_position <= POS_CRC_LAST) begin
        running_crc_next = crc_stepped;
      end
    end
  end

  // Frame summary, valid when result_hit is high.
  always_comb begin
    result.function_code   = crc_match ? frame_bytes[0] : 8'h00;
    result.crc_good        = crc_match;
    result.data_byte_a     = frame_bytes[1];
    result.data_byte_b     = frame_bytes[2];
    result.data_byte_c     = frame_bytes[3];
    result.crc_error_total = error_tally_next;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= POS_IDLE;
      running_crc       <= CRC_INIT;
      crc_high_received <= 8'h00;
      error_tally       <= 16'h0000;
    end else if (byte_take) begin
      byte_position <= byte_position_next;
      running_crc   <= running_crc_next;
      error_tally   <= error_tally_next;
      if (byte_position == POS_CRC_HIGH) begin
        crc_high_received <= rx_byte;
      end
    end
  end

  // Frame bytes one to four, payload only.
  always_ff @(posedge clk) begin
    if (byte_take && (byte_position != POS_IDLE) && (byte_position <= POS_DATA_END)) begin
      frame_bytes[byte_position[1:0] - 2'd1] <= rx_byte;
    end
  end

endmodule

// ===== design/mbrx_out_reg.sv =====
`timescale 1ns / 1ps

module mbrx_out_reg import mbrx_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  result_t     result,
  output logic        busy,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,
  output logic        m_tuser
);

  result_t held;

  // The register can take a new result when empty or being drained.
  assign busy = m_tvalid && !m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

  assign m_tdata = {held.crc_error_total, held.data_byte_c, held.data_byte_b,
                    held.data_byte_a, held.function_code};
  assign m_tuser = held.crc_good;

endmodule

// ===== design/modbus_frame_receive_check.sv =====
`timescale 1ns / 1ps

// Channel   | Direction | Contents
// ----------+-----------+---------------------------------------------------------
// s_        | in        | tdata[7:0] rx_byte
// m_        | out       | tdata function_code, data_byte_a/b/c, crc_error_total;
//           |           | tuser crc_good
// cfg_      | in        | cfg_wdata slave_address, written when cfg_we is high
//
// One word per cycle while the output is not stalled: each received word is held
// in the input register while the byte-wise CRC step, position update and frame
// check run, then the frame summary is loaded into the output register. Reset
// clears the position, CRC, error count and both valid flags; slave_address returns
// to 1. Only a frame-ending word waits for a stalled output; other words pass.

module modbus_frame_receive_check import mbrx_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [7:0] function_code, [15:8] data_byte_a,
                                 // [23:16] data_byte_b, [31:24] data_byte_c,
                                 // [47:32] crc_error_total
  output logic        m_tuser    // [0] crc_good
);

  logic [7:0] slave_address;
  logic       in_valid;
  logic [7:0] in_byte;
  logic       result_hit;
  logic       out_busy;
  logic       advance;
  result_t    result;

  // Slave address register.
  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= 8'd1;
    end else if (cfg_we) begin
      slave_address <= cfg_wdata;
    end
  end

  // The held word moves on unless it ends a frame and the output is stalled.
  assign advance  = in_valid && !(result_hit && out_busy);
  assign s_tready = !in_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  mbrx_frame u_frame (
    .clk           (clk),
    .rst           (rst),
    .slave_address (slave_address),
    .byte_valid    (in_valid),
    .byte_take     (advance),
    .rx_byte       (in_byte),
    .result_hit    (result_hit),
    .result        (result)
  );

  mbrx_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && result_hit),
    .result   (result),
    .busy     (out_busy),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
